/* rtl/csma_pkg.sv */
// Shared types and constants for the slotted CSMA backoff channel.
package csma_pkg;

    localparam int RANGE_COUNT = 4;
    localparam int BACKOFF_W   = 10;
    localparam int COLL_W      = 2;
    localparam int LEN_W       = 16;
    localparam int SLOT_W      = 32;
    localparam int TICK_W      = 32;
    localparam int DIV_W       = TICK_W + 1;
    localparam int NODE_W      = BACKOFF_W + COLL_W;

    // configuration register indexes
    localparam logic [2:0] CFG_NODE_COUNT  = 3'd0;
    localparam logic [2:0] CFG_FRAME_LEN   = 3'd1;
    localparam logic [2:0] CFG_COLL_LIMIT  = 3'd2;
    localparam logic [2:0] CFG_RANGE_0     = 3'd3;
    localparam logic [2:0] CFG_RANGE_1     = 3'd4;
    localparam logic [2:0] CFG_RANGE_2     = 3'd5;
    localparam logic [2:0] CFG_RANGE_3     = 3'd6;

    // channel state codes
    localparam logic [1:0] CH_IDLE = 2'd0;
    localparam logic [1:0] CH_SLOT = 2'd1;
    localparam logic [1:0] CH_END  = 2'd2;
    localparam logic [1:0] CH_COLL = 2'd3;

    // node pass modes
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_COLL  = 2'd1;
    localparam logic [1:0] MODE_DEC   = 2'd2;
    localparam logic [1:0] MODE_END   = 2'd3;

    // node index operations
    localparam logic [2:0] IDX_HOLD = 3'd0;
    localparam logic [2:0] IDX_CLR  = 3'd1;
    localparam logic [2:0] IDX_INC  = 3'd2;
    localparam logic [2:0] IDX_WHO0 = 3'd3;
    localparam logic [2:0] IDX_WHO1 = 3'd4;

    typedef struct packed {
        logic       load_item;
        logic [2:0] idx_op;
        logic [1:0] mode;
        logic       scan_acc;
        logic       mod_start;
        logic       wr_draw;
        logic       wr_dec;
        logic       slot_count;
        logic       frame_end;
        logic       out_load;
        logic [1:0] out_state;
    } cmd_t;

    typedef struct packed {
        logic [1:0] n0;
        logic [1:0] n1;
        logic       idx_lt_active;
        logic       rem_zero;
        logic       node_zero;
        logic       mod_done;
        logic       out_free;
    } stat_t;

endpackage

/* rtl/csma_slot_backoff_channel_core.sv */
// Top level of the slotted CSMA backoff channel: controller plus datapath.
// Start word: each active node draws its backoff through the modulo unit.
// Tick word: accept, node scan, then a slot, or a decrement or collision pass with a modulo
// draw per colliding node, a frame end adds a draw; then hand-off (+ m_tready stalls).
// One word at a time; the next input is taken while the result word waits in m_t*.
// aresetn is synchronous: channel empty, counters cleared, registers at 1.
module csma_slot_backoff_channel_core #(
    parameter int NODES_MAX = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] tick_number
    input  logic [0:0]  s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [5:0] sender_id, [37:6] success_slots
    output logic [1:0]  m_tuser    // [1:0] channel_state
);
    csma_pkg::cmd_t  cmd;
    csma_pkg::stat_t stat;

    csma_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_action (s_tuser[0]),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    csma_dp #(
        .NODES_MAX (NODES_MAX)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_action (s_tuser[0]),
        .in_tick   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata)
    );

endmodule

/* rtl/csma_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module csma_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                   aclk,
    input  logic                   we,
    input  logic [AW-1:0]          waddr,
    input  logic [WIDTH-1:0]       wdata,
    input  logic [AW-1:0]          raddr,
    output logic [WIDTH-1:0]       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/csma_mod.sv */
// Bit-serial restoring modulo unit: dividend mod divisor, one bit per cycle.
module csma_mod (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [csma_pkg::DIV_W-1:0]    dividend,
    input  logic [csma_pkg::BACKOFF_W-1:0] divisor,
    output logic                          busy,
    output logic                          done,
    output logic [csma_pkg::BACKOFF_W-1:0] q
);
    localparam int CNT_W = $clog2(csma_pkg::DIV_W + 1);

    logic [csma_pkg::DIV_W-1:0]     dvd_reg, dvd_next;
    logic [csma_pkg::BACKOFF_W-1:0] dvs_reg, dvs_next;
    logic [csma_pkg::BACKOFF_W-1:0] r_reg, r_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [csma_pkg::BACKOFF_W:0]   sh;

    always_comb begin
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        sh        = {r_reg, dvd_reg[csma_pkg::DIV_W-1]};
        if (start) begin
            dvd_next  = dividend;
            dvs_next  = divisor;
            r_next    = '0;
            cnt_next  = CNT_W'(csma_pkg::DIV_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (sh >= {1'b0, dvs_reg}) begin
                r_next = csma_pkg::BACKOFF_W'(sh - {1'b0, dvs_reg});
            end else begin
                r_next = sh[csma_pkg::BACKOFF_W-1:0];
            end
            dvd_next = {dvd_reg[csma_pkg::DIV_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        r_reg   <= r_next;
    end

    // zero modulus draws zero
    assign q    = (dvs_reg == '0) ? '0 : r_reg;
    assign busy = busy_reg;
    assign done = done_reg;

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg) else $error("modulo restarted while busy");
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (dvs_reg == '0 || r_reg < dvs_reg)) else $error("remainder out of range");
    a_done_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg) else $error("done while busy");

endmodule

/* rtl/csma_dp.sv */
// Datapath: config registers, node RAM, scan counters, modulo unit and output word.
module csma_dp #(
    parameter int NODES_MAX = 64
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [2:0]                 cfg_index,
    input  logic [15:0]                cfg_data,
    input  logic                       in_action,
    input  logic [csma_pkg::TICK_W-1:0] in_tick,
    input  csma_pkg::cmd_t             cmd,
    output csma_pkg::stat_t            stat,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [1:0]                 m_tuser,
    output logic [39:0]                m_tdata
);
    localparam int IW = (NODES_MAX > 1) ? $clog2(NODES_MAX) : 1;
    localparam int AW = $clog2(NODES_MAX + 1);

    logic [6:0]                      node_count_reg;
    logic [csma_pkg::LEN_W-1:0]      frame_len_reg;
    logic [2:0]                      coll_limit_reg;
    logic [csma_pkg::BACKOFF_W-1:0]  range_reg [csma_pkg::RANGE_COUNT];

    logic [AW-1:0]                   active_reg, idx_reg, idx_next;
    logic [csma_pkg::TICK_W-1:0]     tick_reg;
    logic                            start_reg;
    logic [1:0]                      n0_reg, n1_reg;
    logic [IW-1:0]                   who0_reg, who1_reg;
    logic [csma_pkg::LEN_W-1:0]      rem_reg;
    logic [csma_pkg::SLOT_W-1:0]     slot_reg;
    logic [csma_pkg::COLL_W-1:0]     coll_hold_reg;
    logic                            out_valid_reg;
    logic [1:0]                      out_state_reg;
    logic [5:0]                      out_sender_reg;
    logic [csma_pkg::SLOT_W-1:0]     out_slots_reg;

    logic [csma_pkg::NODE_W-1:0]     rd_word, wr_word;
    logic [csma_pkg::BACKOFF_W-1:0]  rd_b;
    logic [csma_pkg::COLL_W-1:0]     rd_c, c_wrap, c_new;
    logic [2:0]                      lim, c_inc;
    logic [csma_pkg::DIV_W-1:0]      dividend;
    logic [csma_pkg::BACKOFF_W-1:0]  mod_q;
    logic                            mod_busy, mod_done;
    logic                            ram_we;
    logic [8:0]                      idx_ext;
    logic [AW-1:0]                   active_clamp;

    assign rd_b = rd_word[csma_pkg::BACKOFF_W-1:0];
    assign rd_c = rd_word[csma_pkg::NODE_W-1:csma_pkg::BACKOFF_W];

    // collision count wraps at the limit, a limit of zero or above the range count acts as it
    always_comb begin
        if (coll_limit_reg == 3'd0 || coll_limit_reg > 3'(csma_pkg::RANGE_COUNT)) begin
            lim = 3'(csma_pkg::RANGE_COUNT);
        end else begin
            lim = coll_limit_reg;
        end
        c_inc  = {1'b0, rd_c} + 3'd1;
        c_wrap = (c_inc >= lim) ? '0 : c_inc[csma_pkg::COLL_W-1:0];
        unique case (cmd.mode)
            csma_pkg::MODE_START: c_new = '0;
            csma_pkg::MODE_COLL:  c_new = c_wrap;
            default:              c_new = rd_c;
        endcase
        if (cmd.mode == csma_pkg::MODE_START) begin
            dividend = csma_pkg::DIV_W'(idx_reg);
        end else begin
            dividend = {1'b0, tick_reg} + csma_pkg::DIV_W'(idx_reg);
        end
    end

    assign ram_we  = cmd.wr_draw | cmd.wr_dec;
    assign wr_word = cmd.wr_draw ? {coll_hold_reg, mod_q} : {rd_c, rd_b - 1'b1};

    csma_ram #(
        .WIDTH (csma_pkg::NODE_W),
        .DEPTH (NODES_MAX)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_reg[IW-1:0]),
        .wdata (wr_word),
        .raddr (idx_reg[IW-1:0]),
        .rdata (rd_word)
    );

    csma_mod u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.mod_start),
        .dividend (dividend),
        .divisor  (range_reg[c_new]),
        .busy     (mod_busy),
        .done     (mod_done),
        .q        (mod_q)
    );

    always_comb begin
        idx_next = idx_reg;
        unique case (cmd.idx_op)
            csma_pkg::IDX_HOLD: idx_next = idx_reg;
            csma_pkg::IDX_CLR:  idx_next = '0;
            csma_pkg::IDX_INC:  idx_next = idx_reg + 1'b1;
            csma_pkg::IDX_WHO0: idx_next = AW'(who0_reg);
            csma_pkg::IDX_WHO1: idx_next = AW'(who1_reg);
            default:            idx_next = idx_reg;
        endcase
    end

    assign active_clamp = ({2'b00, node_count_reg} > 9'(NODES_MAX)) ?
                          AW'(NODES_MAX) : AW'(node_count_reg);
    assign idx_ext = 9'(idx_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= 7'd1;
            frame_len_reg  <= 16'd1;
            coll_limit_reg <= 3'd1;
            for (int i = 0; i < csma_pkg::RANGE_COUNT; i++) begin
                range_reg[i] <= 10'd1;
            end
            active_reg    <= '0;
            idx_reg       <= '0;
            rem_reg       <= 16'd1;
            slot_reg      <= '0;
            n0_reg        <= '0;
            n1_reg        <= '0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    csma_pkg::CFG_NODE_COUNT: node_count_reg <= cfg_data[6:0];
                    csma_pkg::CFG_FRAME_LEN:  frame_len_reg  <= cfg_data;
                    csma_pkg::CFG_COLL_LIMIT: coll_limit_reg <= cfg_data[2:0];
                    csma_pkg::CFG_RANGE_0:    range_reg[0]   <= cfg_data[9:0];
                    csma_pkg::CFG_RANGE_1:    range_reg[1]   <= cfg_data[9:0];
                    csma_pkg::CFG_RANGE_2:    range_reg[2]   <= cfg_data[9:0];
                    csma_pkg::CFG_RANGE_3:    range_reg[3]   <= cfg_data[9:0];
                    default: ;
                endcase
            end
            idx_reg <= idx_next;
            if (cmd.load_item) begin
                start_reg <= !in_action;
                n0_reg    <= '0;
                n1_reg    <= '0;
                if (!in_action) begin
                    active_reg <= active_clamp;
                    rem_reg    <= frame_len_reg;
                    slot_reg   <= '0;
                end
            end
            if (cmd.scan_acc) begin
                if (rd_b == '0 && n0_reg != 2'd2) begin
                    n0_reg <= n0_reg + 1'b1;
                end
                if (rd_b == 10'd1 && n1_reg != 2'd2) begin
                    n1_reg <= n1_reg + 1'b1;
                end
            end
            if (cmd.slot_count) begin
                rem_reg  <= rem_reg - 1'b1;
                slot_reg <= slot_reg + 1'b1;
            end
            if (cmd.frame_end) begin
                rem_reg <= frame_len_reg;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (cmd.load_item) begin
            tick_reg <= in_tick;
        end
        if (cmd.scan_acc && rd_b == '0) begin
            who0_reg <= idx_reg[IW-1:0];
        end
        if (cmd.scan_acc && rd_b == 10'd1) begin
            who1_reg <= idx_reg[IW-1:0];
        end
        if (cmd.mod_start) begin
            coll_hold_reg <= c_new;
        end
        if (cmd.out_load) begin
            out_state_reg <= cmd.out_state;
            out_slots_reg <= slot_reg;
            if (cmd.out_state == csma_pkg::CH_SLOT || cmd.out_state == csma_pkg::CH_END) begin
                out_sender_reg <= idx_ext[5:0];
            end else begin
                out_sender_reg <= '0;
            end
        end
    end

    assign stat.n0            = n0_reg;
    assign stat.n1            = n1_reg;
    assign stat.idx_lt_active = idx_reg < active_reg;
    assign stat.rem_zero      = rem_reg == '0;
    assign stat.node_zero     = rd_b == '0;
    assign stat.mod_done      = mod_done;
    assign stat.out_free      = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_state_reg;
    assign m_tdata  = {2'b00, out_slots_reg, out_sender_reg};

    a_one_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.wr_draw && cmd.wr_dec)) else $error("two node writes at once");
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || m_tready)) else $error("output word overwritten");
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && start_reg) |-> cmd.out_state == csma_pkg::CH_IDLE)
        else $error("start word not idle");
    a_mod_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mod_start |-> !mod_busy) else $error("modulo started while busy");

endmodule

/* rtl/csma_ctrl.sv */
// Controller: sequences node scan, update passes, frame end draw and result hand-off.
module csma_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    input  logic            s_action,
    output logic            s_tready,
    input  csma_pkg::stat_t stat,
    output csma_pkg::cmd_t  cmd
);
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SCAN    = 4'd1;
    localparam logic [3:0] S_SCAN_WT = 4'd2;
    localparam logic [3:0] S_DECIDE  = 4'd3;
    localparam logic [3:0] S_LOOP    = 4'd4;
    localparam logic [3:0] S_LOOP_WT = 4'd5;
    localparam logic [3:0] S_MOD     = 4'd6;
    localparam logic [3:0] S_TX      = 4'd7;
    localparam logic [3:0] S_END_WT  = 4'd8;
    localparam logic [3:0] S_DONE    = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [1:0] mode_reg, mode_next;
    logic [1:0] out_reg, out_next;

    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        out_next   = out_reg;
        cmd        = '0;
        cmd.idx_op = csma_pkg::IDX_HOLD;
        cmd.mode   = mode_reg;
        cmd.out_state = out_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    cmd.idx_op    = csma_pkg::IDX_CLR;
                    if (!s_action) begin
                        mode_next  = csma_pkg::MODE_START;
                        state_next = S_LOOP;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                state_next = stat.idx_lt_active ? S_SCAN_WT : S_DECIDE;
            end
            S_SCAN_WT: begin
                cmd.scan_acc = 1'b1;
                cmd.idx_op   = csma_pkg::IDX_INC;
                state_next   = S_SCAN;
            end
            S_DECIDE: begin
                if (stat.n0 == 2'd1) begin
                    cmd.idx_op = csma_pkg::IDX_WHO0;
                    state_next = S_TX;
                end else begin
                    mode_next  = stat.n0[1] ? csma_pkg::MODE_COLL : csma_pkg::MODE_DEC;
                    cmd.idx_op = csma_pkg::IDX_CLR;
                    state_next = S_LOOP;
                end
            end
            S_LOOP: begin
                if (stat.idx_lt_active) begin
                    state_next = S_LOOP_WT;
                end else begin
                    unique case (mode_reg)
                        csma_pkg::MODE_COLL: begin
                            out_next   = csma_pkg::CH_COLL;
                            state_next = S_DONE;
                        end
                        csma_pkg::MODE_DEC: begin
                            // exactly one node just reached zero: it sends this tick
                            if (stat.n1 == 2'd1) begin
                                cmd.idx_op = csma_pkg::IDX_WHO1;
                                state_next = S_TX;
                            end else begin
                                out_next   = csma_pkg::CH_IDLE;
                                state_next = S_DONE;
                            end
                        end
                        default: begin
                            out_next   = csma_pkg::CH_IDLE;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_LOOP_WT: begin
                unique case (mode_reg)
                    csma_pkg::MODE_COLL: begin
                        if (stat.node_zero) begin
                            cmd.mod_start = 1'b1;
                            state_next    = S_MOD;
                        end else begin
                            cmd.idx_op = csma_pkg::IDX_INC;
                            state_next = S_LOOP;
                        end
                    end
                    csma_pkg::MODE_DEC: begin
                        cmd.wr_dec = !stat.node_zero;
                        cmd.idx_op = csma_pkg::IDX_INC;
                        state_next = S_LOOP;
                    end
                    default: begin
                        cmd.mod_start = 1'b1;
                        state_next    = S_MOD;
                    end
                endcase
            end
            S_TX: begin
                if (stat.rem_zero) begin
                    cmd.frame_end = 1'b1;
                    mode_next     = csma_pkg::MODE_END;
                    state_next    = S_END_WT;
                end else begin
                    cmd.slot_count = 1'b1;
                    out_next       = csma_pkg::CH_SLOT;
                    state_next     = S_DONE;
                end
            end
            S_END_WT: begin
                cmd.mod_start = 1'b1;
                state_next    = S_MOD;
            end
            S_MOD: begin
                if (stat.mod_done) begin
                    cmd.wr_draw = 1'b1;
                    if (mode_reg == csma_pkg::MODE_END) begin
                        out_next   = csma_pkg::CH_END;
                        state_next = S_DONE;
                    end else begin
                        cmd.idx_op = csma_pkg::IDX_INC;
                        state_next = S_LOOP;
                    end
                end
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mode_reg  <= csma_pkg::MODE_START;
            out_reg   <= csma_pkg::CH_IDLE;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            out_reg   <= out_next;
        end
    end

    a_wait_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MOD && !stat.mod_done) |=> state_reg == S_MOD)
        else $error("left modulo wait early");
    a_draw_in_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_draw |-> state_reg == S_MOD) else $error("draw written outside modulo wait");

endmodule

/* dv/tb.sv */
// Testbench for the slotted CSMA backoff channel core: stream driver, monitor, predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NMAX = 64;

    typedef struct packed {
        logic        action;
        logic [31:0] tick;
    } tick_word_t;

    typedef struct packed {
        logic [1:0]  state;
        logic [5:0]  sender;
        logic [31:0] slots;
    } chan_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = csma_pkg::CFG_NODE_COUNT;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    csma_slot_backoff_channel_core #(.NODES_MAX(NMAX)) DUT (.*);

    // predictor state
    logic [6:0]  p_node_count;
    logic [15:0] p_frame_len;
    logic [2:0]  p_coll_limit;
    logic [9:0]  p_range [csma_pkg::RANGE_COUNT];
    logic [9:0]  p_backoff [NMAX];
    logic [1:0]  p_coll [NMAX];
    logic        p_ready [NMAX];
    logic [15:0] p_remaining;
    logic [31:0] p_slots;
    int          p_active;

    tick_word_t   pending_words[$];
    chan_result_t expected_results[$];
    int errors = 0, words_sent = 0, results_seen = 0, collisions = 0, frame_ends = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic model_reset();
        p_node_count = 7'd1; p_frame_len = 16'd1; p_coll_limit = 3'd1;
        for (int i = 0; i < csma_pkg::RANGE_COUNT; i++) p_range[i] = 10'd1;
        for (int i = 0; i < NMAX; i++) begin
            p_backoff[i] = '0; p_coll[i] = '0; p_ready[i] = 1'b0;
        end
        p_remaining = 16'd1; p_slots = '0; p_active = 0;
    endtask

    task automatic model_write(input logic [2:0] idx, input logic [15:0] val);
        case (idx)
            csma_pkg::CFG_NODE_COUNT: p_node_count = val[6:0];
            csma_pkg::CFG_FRAME_LEN:  p_frame_len  = val;
            csma_pkg::CFG_COLL_LIMIT: p_coll_limit = val[2:0];
            csma_pkg::CFG_RANGE_0:    p_range[0]   = val[9:0];
            csma_pkg::CFG_RANGE_1:    p_range[1]   = val[9:0];
            csma_pkg::CFG_RANGE_2:    p_range[2]   = val[9:0];
            csma_pkg::CFG_RANGE_3:    p_range[3]   = val[9:0];
            default: ;
        endcase
    endtask

    function automatic void redraw(input int id, input logic [31:0] tk);
        logic [9:0] m;
        logic [32:0] b;
        m = p_range[p_coll[id]];
        b = (m == 0) ? 33'd0 : (33'(id) + 33'(tk)) % 33'(m);
        p_backoff[id] = b[9:0];
        p_ready[id] = (b == 0);
    endfunction

    function automatic int ready_count(output int who);
        int n = 0;
        who = 0;
        for (int i = 0; i < p_active; i++) if (p_ready[i]) begin
            n++; who = i;
        end
        return n;
    endfunction

    function automatic logic [1:0] own_channel(input int id, input logic [31:0] tk);
        if (p_remaining == 0) begin
            p_remaining = p_frame_len;
            redraw(id, tk);
            return csma_pkg::CH_END;
        end
        p_backoff[id] = '0;
        p_remaining--;
        p_slots++;
        return csma_pkg::CH_SLOT;
    endfunction

    function automatic chan_result_t channel_step(input tick_word_t w);
        chan_result_t r;
        int who, n, lim;
        logic [2:0] c;
        r = '0;
        if (!w.action) begin
            p_active = (p_node_count > NMAX) ? NMAX : int'(p_node_count);
            for (int i = 0; i < NMAX; i++) begin
                p_backoff[i] = '0; p_coll[i] = '0; p_ready[i] = 1'b0;
            end
            for (int i = 0; i < p_active; i++) redraw(i, 32'd0);
            p_remaining = p_frame_len;
            p_slots = '0;
            r.state = csma_pkg::CH_IDLE;
        end else begin
            n = ready_count(who);
            if (n == 1) begin
                r.state = own_channel(who, w.tick);
                r.sender = who[5:0];
            end else if (n > 1) begin
                lim = int'(p_coll_limit);
                if (lim == 0 || lim > csma_pkg::RANGE_COUNT) lim = csma_pkg::RANGE_COUNT;
                for (int i = 0; i < p_active; i++) if (p_ready[i]) begin
                    c = {1'b0, p_coll[i]} + 3'd1;
                    p_coll[i] = (c >= 3'(lim)) ? 2'd0 : c[1:0];
                    redraw(i, w.tick);
                end
                r.state = csma_pkg::CH_COLL;
            end else begin
                for (int i = 0; i < p_active; i++) if (p_backoff[i] != 0) begin
                    p_backoff[i]--;
                    if (p_backoff[i] == 0) p_ready[i] = 1'b1;
                end
                if (ready_count(who) == 1) begin
                    r.state = own_channel(who, w.tick);
                    r.sender = who[5:0];
                end else begin
                    r.state = csma_pkg::CH_IDLE;
                end
            end
        end
        r.slots = p_slots;
        return r;
    endfunction

    // idle pattern: quiet window in the middle of the run, long hold-off once
    bit quiet = 0;
    int hold_off = 0;
    bit hold_req = 0;
    bit hold_used = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_words.size() != 0 && (quiet || $urandom_range(99) >= 18)) begin
                s_tvalid <= 1'b1;
                {s_tuser, s_tdata} <= pending_words[0];
                expected_results.insert(expected_results.size(),
                                        channel_step(pending_words.pop_front()));
                words_sent++;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        chan_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.state = m_tuser;
            got.sender = m_tdata[5:0];
            got.slots = m_tdata[37:6];
            results_seen++;
            if (got.state == csma_pkg::CH_COLL) collisions++;
            if (got.state == csma_pkg::CH_END) frame_ends++;
            if (expected_results.size() == 0) begin
                $error("unexpected result word state=%0d", got.state);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.state !== want.state) begin
                    $error("channel_state exp %0d got %0d", want.state, got.state); errors++;
                end
                if (got.sender !== want.sender) begin
                    $error("sender_id exp %0d got %0d", want.sender, got.sender); errors++;
                end
                if (got.slots !== want.slots) begin
                    $error("success_slots exp %0d got %0d", want.slots, got.slots); errors++;
                end
            end
        end
    end

    // receiver side: random idling, plus one long hold-off counted here
    always @(posedge aclk) begin
        if (hold_req && !hold_used && hold_off == 0) begin
            hold_off  <= 3000;
            hold_used <= 1'b1;
            m_tready  <= 1'b0;
        end else if (hold_off != 0) begin
            hold_off <= hold_off - 1;
            m_tready <= (hold_off == 1);
        end else begin
            m_tready <= aresetn && (quiet || $urandom_range(99) >= 18);
        end
    end

    task automatic wait_drained();
        while (pending_words.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (8000) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_data <= val;
        model_write(idx, val);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_word(input bit act, input logic [31:0] tk);
        tick_word_t w;
        w.action = act; w.tick = tk;
        pending_words.insert(pending_words.size(), w);
    endtask

    task automatic setup_channel(input int nodes, input int flen, input int lim,
                                 input int r0, input int r1, input int r2, input int r3);
        write_reg(csma_pkg::CFG_NODE_COUNT, 16'(nodes));
        write_reg(csma_pkg::CFG_FRAME_LEN, 16'(flen));
        write_reg(csma_pkg::CFG_COLL_LIMIT, 16'(lim));
        write_reg(csma_pkg::CFG_RANGE_0, 16'(r0));
        write_reg(csma_pkg::CFG_RANGE_1, 16'(r1));
        write_reg(csma_pkg::CFG_RANGE_2, 16'(r2));
        write_reg(csma_pkg::CFG_RANGE_3, 16'(r3));
    endtask

    task automatic random_phase(input int n);
        logic [31:0] tk;
        tk = $urandom;
        queue_word(1'b0, $urandom);
        for (int i = 1; i < n; i++) begin
            if ($urandom_range(99) < 3) queue_word(1'b0, $urandom);
            else if ($urandom_range(99) < 10) queue_word(1'b1, $urandom);
            else queue_word(1'b1, tk++);
        end
    endtask

    initial begin
        model_reset();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // ticks before any start, then the reset configuration
        queue_word(1'b1, 32'hFFFF_FFFF);
        queue_word(1'b1, 32'd0);
        queue_word(1'b0, 32'hFFFF_FFFF);
        queue_word(1'b1, 32'd5);
        queue_word(1'b1, 32'd6);
        wait_drained();

        // empty channel, then zero ranges, zero frame length, zero limit
        setup_channel(0, 0, 0, 0, 0, 0, 0);
        queue_word(1'b0, 32'd0);
        queue_word(1'b1, 32'd1);
        wait_drained();
        write_reg(csma_pkg::CFG_NODE_COUNT, 16'd4);
        for (int i = 0; i < 6; i++) queue_word(1'(i != 0), 32'hFFFF_FFF0 + 32'(i));
        wait_drained();

        // over-range node count and limit, wide ranges, long frame
        setup_channel(127, 65535, 7, 1023, 1023, 1023, 1023);
        for (int i = 0; i < 6; i++) queue_word(1'(i != 0), 32'h8000_0000 + 32'(i));
        wait_drained();

        // small settings, a single node that sends and reaches a frame end
        setup_channel(1, 1, 4, 3, 2, 5, 7);
        for (int i = 0; i < 5; i++) queue_word(1'(i != 0), 32'(i));
        wait_drained();

        for (int ph = 0; ph < 10; ph++) begin
            quiet = (ph == 4);
            hold_req = (ph == 6);
            setup_channel($urandom_range(1, (ph == 8) ? 64 : 12), $urandom_range(0, 4),
                          $urandom_range(0, 7), $urandom_range(0, 9), $urandom_range(0, 17),
                          $urandom_range(1, 33), $urandom_range(0, 1023));
            random_phase(160);
            wait_drained();
        end

        $display("Sent %0d words, checked %0d results (%0d collisions, %0d frame ends).",
                 words_sent, results_seen, collisions, frame_ends);
        if (errors == 0)
            $display("PASS csma_slot_backoff_channel_core");
        else
            $display("FAIL csma_slot_backoff_channel_core");
        $finish;
    end

    initial begin
        #200ms;
        $display("FAIL csma_slot_backoff_channel_core");
        $finish;
    end
endmodule
